### rtl/plli_pkg.sv
`timescale 1ns / 1ps

package plli_pkg;

	localparam int TEMP_W   = 20;
	localparam int CHROMA_W = 16;
	localparam int FRAC_W   = 17;

	typedef logic [1:0] status_t;

	localparam status_t ST_INTERP     = 2'd0;
	localparam status_t ST_CLAMP_LO   = 2'd1;
	localparam status_t ST_CLAMP_HI   = 2'd2;
	localparam status_t ST_NO_BRACKET = 2'd3;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_ENTRIES = 1'b0;

	localparam logic [9:0] ENTRIES_RESET = 10'd512;

	typedef struct packed {
		logic [TEMP_W-1:0]   temp;
		logic [CHROMA_W-1:0] u;
		logic [CHROMA_W-1:0] v;
	} entry_t;

	typedef struct packed {
		logic              go;
		logic [TEMP_W-1:0] num;
		logic [TEMP_W-1:0] den;
	} div_req_t;

endpackage

### rtl/plli_table.sv
`timescale 1ns / 1ps

module plli_table #(
	parameter int AW = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  plli_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output plli_pkg::entry_t rdata
);
	import plli_pkg::*;

	entry_t mem [2**AW];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/plli_div.sv
`timescale 1ns / 1ps

module plli_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  plli_pkg::div_req_t          req,
	output logic                        done,
	output logic [plli_pkg::FRAC_W-1:0] quot
);
	import plli_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [4:0]          cnt_q;
	logic [TEMP_W:0]     rem_q;
	logic [TEMP_W-1:0]   den_q;
	logic [FRAC_W-1:0]   quot_q;
	logic                ge;
	logic [TEMP_W:0]     diff_w;
	logic [TEMP_W:0]     rem_next;

	assign ge       = rem_q >= {1'b0, den_q};
	assign diff_w   = rem_q - {1'b0, den_q};
	assign rem_next = ge ? diff_w : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(FRAC_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q  <= {rem_next[TEMP_W-1:0], 1'b0};
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q)
		else $error("divide started while busy");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cnt_q == '0) |=> done_q && !busy_q)
		else $error("divide did not finish after last step");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divide done without work");

endmodule

### rtl/planckian_locus_interpolator.sv
`timescale 1ns / 1ps

// Planckian locus interpolator.
// Command channel: drive start with func, observer and the entry or query
// fields; the item transfers at a clock edge with start high and busy low.
// A load (func 0) writes one table entry in that cycle and gives no result;
// busy stays low, so loads can stream one per cycle.
// A query (func 1) raises busy until done; done is high for one cycle with
// locus_u, locus_v and status, and the receiver must take it then.
// A query reads the first entry (low clamp), then the last (high clamp),
// then makes a linear scan of the table at one entry per cycle through the
// single read port (with no bracket, u and v are zero); a zero-width bracket
// pair gives its low entry, else a serial divide gives the fraction and u
// then v take a multiply-add on one shared multiplier.
// A new item may transfer in the cycle done is high.
// Configuration over APB: entries_in_use at byte address 0, reset 512.
// Reset clears the sequencer and sets the register to 512; table contents
// are undefined until loaded.
module planckian_locus_interpolator #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic                    observer,
	input  logic [8:0]              entry_index,
	input  logic [19:0]             entry_temperature,
	input  logic [15:0]             entry_u,
	input  logic [15:0]             entry_v,
	input  logic [19:0]             query_temperature,
	output logic                    done,
	output logic [15:0]             locus_u,
	output logic [15:0]             locus_v,
	output plli_pkg::status_t       status
);
	import plli_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int AW = IW + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FIRST  = 4'd1;
	localparam logic [3:0] S_LAST   = 4'd2;
	localparam logic [3:0] S_PRIME  = 4'd3;
	localparam logic [3:0] S_SCAN   = 4'd4;
	localparam logic [3:0] S_DSTART = 4'd5;
	localparam logic [3:0] S_DWAIT  = 4'd6;
	localparam logic [3:0] S_MULU   = 4'd7;
	localparam logic [3:0] S_MULV   = 4'd8;

	logic [3:0]          state_q;
	logic                done_q;
	logic [9:0]          entries_q;
	logic                obs_q;
	logic [TEMP_W-1:0]   q_q;
	logic [IW-1:0]       last_q;
	logic [IW-1:0]       ptr_q;
	entry_t              prev_q;
	entry_t              lo_q;
	entry_t              hi_q;
	logic [15:0]         u_q;
	logic [15:0]         v_q;
	status_t             status_q;

	logic                accept;
	logic                we;
	logic [31:0]         idx32;
	logic [31:0]         n32;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	entry_t              wdata;
	entry_t              rdata;
	logic                hit;
	logic [TEMP_W-1:0]   span;
	div_req_t            div_req;
	logic                div_done;
	logic [FRAC_W-1:0]   frac;
	logic [15:0]         mul_a;
	logic [15:0]         mul_b;
	logic signed [16:0]  delta;
	logic signed [34:0]  prod;
	logic signed [35:0]  acc;
	logic [15:0]         lerp;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ENTRIES) ? {22'd0, entries_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES)) begin
			entries_q <= pwdata[9:0];
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign idx32 = {23'd0, entry_index};
	assign we    = accept && (func == FUNC_LOAD) && (idx32 < TABLE_DEPTH);
	assign waddr = {observer, idx32[IW-1:0]};
	assign wdata = '{temp: entry_temperature, u: entry_u, v: entry_v};

	always_comb begin
		if (entries_q < 10'd2) begin
			n32 = 32'd2;
		end else if ({22'd0, entries_q} > TABLE_DEPTH) begin
			n32 = 32'(TABLE_DEPTH);
		end else begin
			n32 = {22'd0, entries_q};
		end
	end

	always_comb begin
		case (state_q)
			S_IDLE:  raddr = {observer, {IW{1'b0}}};
			S_FIRST: raddr = {obs_q, last_q};
			S_LAST:  raddr = {obs_q, {IW{1'b0}}};
			S_PRIME: raddr = {obs_q, IW'(1)};
			S_SCAN:  raddr = {obs_q, IW'(ptr_q + IW'(1))};
			default: raddr = {obs_q, ptr_q};
		endcase
	end

	plli_table #(.AW(AW)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign hit  = (prev_q.temp <= q_q) && (q_q <= rdata.temp);
	assign span = hi_q.temp - lo_q.temp;

	assign div_req.go  = (state_q == S_DSTART) && (span != '0);
	assign div_req.num = q_q - lo_q.temp;
	assign div_req.den = span;

	plli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (frac)
	);

	// shared multiply-add: lo + t * (hi - lo), t in Q1.16
	assign mul_a = (state_q == S_MULU) ? lo_q.u : lo_q.v;
	assign mul_b = (state_q == S_MULU) ? hi_q.u : hi_q.v;
	assign delta = $signed({1'b0, mul_b}) - $signed({1'b0, mul_a});
	assign prod  = $signed({1'b0, frac}) * delta;
	assign acc   = $signed({4'd0, mul_a, 16'd0}) + $signed({prod[34], prod});
	assign lerp  = acc[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (func == FUNC_QUERY)) begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					if (q_q <= rdata.temp) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (q_q >= rdata.temp) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PRIME;
					end
				end
				S_PRIME: state_q <= S_SCAN;
				S_SCAN: begin
					if (hit) begin
						state_q <= S_DSTART;
					end else if (ptr_q == last_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DSTART: begin
					if (span == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					if (div_done) begin
						state_q <= S_MULU;
					end
				end
				S_MULU: state_q <= S_MULV;
				S_MULV: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					obs_q  <= observer;
					q_q    <= query_temperature;
					last_q <= IW'(n32 - 32'd1);
				end
			end
			S_FIRST: begin
				u_q      <= rdata.u;
				v_q      <= rdata.v;
				status_q <= ST_CLAMP_LO;
			end
			S_LAST: begin
				u_q      <= rdata.u;
				v_q      <= rdata.v;
				status_q <= ST_CLAMP_HI;
			end
			S_PRIME: begin
				prev_q <= rdata;
				ptr_q  <= IW'(1);
			end
			S_SCAN: begin
				lo_q     <= prev_q;
				hi_q     <= rdata;
				prev_q   <= rdata;
				ptr_q    <= ptr_q + IW'(1);
				u_q      <= '0;
				v_q      <= '0;
				status_q <= ST_NO_BRACKET;
			end
			S_DSTART: begin
				u_q      <= lo_q.u;
				v_q      <= lo_q.v;
				status_q <= ST_INTERP;
			end
			S_MULU: u_q <= lerp;
			S_MULV: v_q <= lerp;
			default: begin
				u_q <= u_q;
			end
		endcase
	end

	assign done    = done_q;
	assign locus_u = u_q;
	assign locus_v = v_q;
	assign status  = status_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a query in flight");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_QUERY) |=> busy)
		else $error("query transfer did not start the sequencer");

	a_no_bracket_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_NO_BRACKET) |-> (locus_u == 16'd0) && (locus_v == 16'd0))
		else $error("no-bracket result not zero");

endmodule

### tb/plli_locus_checker.sv
`timescale 1ns / 1ps

module plli_locus_checker #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	input  logic [31:0]                   prdata,
	input  logic                          pready,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          func,
	input  logic                          observer,
	input  logic [8:0]                    entry_index,
	input  logic [plli_pkg::TEMP_W-1:0]   entry_temperature,
	input  logic [plli_pkg::CHROMA_W-1:0] entry_u,
	input  logic [plli_pkg::CHROMA_W-1:0] entry_v,
	input  logic [plli_pkg::TEMP_W-1:0]   query_temperature,
	input  logic                          done,
	input  logic [plli_pkg::CHROMA_W-1:0] locus_u,
	input  logic [plli_pkg::CHROMA_W-1:0] locus_v,
	input  plli_pkg::status_t             status,
	output int unsigned                   mismatches,
	output int unsigned                   pending
);
	import plli_pkg::*;

	localparam logic [2:0] ENTRIES_ADDR = {REG_ENTRIES, 2'b00};

	typedef struct packed {
		logic [CHROMA_W-1:0] u;
		logic [CHROMA_W-1:0] v;
		status_t             st;
	} locus_pt_t;

	entry_t      locus_tab [2][TABLE_DEPTH];
	logic [9:0]  entries_cfg;
	locus_pt_t   expected_locus [$];

	initial begin
		entries_cfg = ENTRIES_RESET;
		mismatches  = 0;
		pending     = 0;
	end

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatches < 100)
			$display("mismatch %s: want %0h got %0h at %0t", field, want, got, $time);
		mismatches++;
	endtask

	function automatic logic [CHROMA_W-1:0] blend_chroma(logic [CHROMA_W-1:0] a,
			logic [CHROMA_W-1:0] b, longint unsigned frac);
		longint unsigned acc;
		acc = 64'(a) * (64'd65536 - frac) + 64'(b) * frac;
		return CHROMA_W'(acc >> 16);
	endfunction

	function automatic locus_pt_t predict_locus(logic obs, logic [TEMP_W-1:0] q);
		locus_pt_t       r;
		int unsigned     n;
		int unsigned     i;
		longint unsigned frac;
		entry_t          lo;
		entry_t          hi;
		bit              found;
		n = entries_cfg;
		if (n < 2)
			n = 2;
		if (n > TABLE_DEPTH)
			n = TABLE_DEPTH;
		r = '0;
		r.st = ST_NO_BRACKET;
		found = 0;
		if (q <= locus_tab[obs][0].temp) begin
			r.u = locus_tab[obs][0].u;
			r.v = locus_tab[obs][0].v;
			r.st = ST_CLAMP_LO;
		end else if (q >= locus_tab[obs][n-1].temp) begin
			r.u = locus_tab[obs][n-1].u;
			r.v = locus_tab[obs][n-1].v;
			r.st = ST_CLAMP_HI;
		end else begin
			for (i = 0; i < n - 1; i++) begin
				lo = locus_tab[obs][i];
				hi = locus_tab[obs][i+1];
				if (!found && q >= lo.temp && q <= hi.temp) begin
					found = 1;
					r.st = ST_INTERP;
					if (hi.temp == lo.temp) begin
						r.u = lo.u;
						r.v = lo.v;
					end else begin
						frac = (64'(q - lo.temp) << 16) / 64'(hi.temp - lo.temp);
						r.u = blend_chroma(lo.u, hi.u, frac);
						r.v = blend_chroma(lo.v, hi.v, frac);
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		locus_pt_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_locus.size() == 0) begin
					report_mismatch("unexpected result", 32'd0, {locus_u, locus_v});
				end else begin
					want = expected_locus.pop_front();
					if (locus_u !== want.u)
						report_mismatch("locus_u", want.u, locus_u);
					if (locus_v !== want.v)
						report_mismatch("locus_v", want.v, locus_v);
					if (status !== want.st)
						report_mismatch("status", want.st, status);
				end
			end
			if (psel && penable && pready && pwrite && paddr == ENTRIES_ADDR)
				entries_cfg = pwdata[9:0];
			if (psel && penable && pready && !pwrite && paddr == ENTRIES_ADDR) begin
				if (prdata !== {22'd0, entries_cfg})
					report_mismatch("prdata", {22'd0, entries_cfg}, prdata);
			end
			if (start && !busy) begin
				if (func == FUNC_LOAD)
					locus_tab[observer][entry_index] = {entry_temperature, entry_u, entry_v};
				else
					expected_locus.push_back(predict_locus(observer, query_temperature));
			end
			pending = expected_locus.size();
		end
	end

endmodule

### tb/tb_planckian_locus_interpolator.sv
`timescale 1ns / 1ps

module tb_planckian_locus_interpolator;
	import plli_pkg::*;

	localparam int          TABLE_DEPTH  = 512;
	localparam int          STALL_LIMIT  = 4000;
	localparam int          RANDOM_ITEMS = 500;
	localparam logic [2:0]  ENTRIES_ADDR = {REG_ENTRIES, 2'b00};
	localparam logic [19:0] TEMP_MAX     = 20'hFFFFF;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic                func;
	logic                observer;
	logic [8:0]          entry_index;
	logic [TEMP_W-1:0]   entry_temperature;
	logic [CHROMA_W-1:0] entry_u;
	logic [CHROMA_W-1:0] entry_v;
	logic [TEMP_W-1:0]   query_temperature;
	logic                done;
	logic [CHROMA_W-1:0] locus_u;
	logic [CHROMA_W-1:0] locus_v;
	status_t             status;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned stall_cycles;
	int unsigned items_sent;
	bit          no_gaps;
	logic [TEMP_W-1:0] loaded_temp [2][TABLE_DEPTH];

	planckian_locus_interpolator #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .func(func), .observer(observer),
		.entry_index(entry_index), .entry_temperature(entry_temperature),
		.entry_u(entry_u), .entry_v(entry_v), .query_temperature(query_temperature),
		.done(done), .locus_u(locus_u), .locus_v(locus_v), .status(status)
	);

	plli_locus_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .func(func), .observer(observer),
		.entry_index(entry_index), .entry_temperature(entry_temperature),
		.entry_u(entry_u), .entry_v(entry_v), .query_temperature(query_temperature),
		.done(done), .locus_u(locus_u), .locus_v(locus_v), .status(status),
		.mismatches(mismatches), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[planckian_locus_interpolator] ERROR");
				$finish;
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// enter and leave just after a falling edge
	task automatic send_item(input logic f, input logic obs, input logic [8:0] idx,
			input logic [19:0] et, input logic [15:0] eu, input logic [15:0] ev,
			input logic [19:0] qt);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start             <= 1'b1;
		func              <= f;
		observer          <= obs;
		entry_index       <= idx;
		entry_temperature <= et;
		entry_u           <= eu;
		entry_v           <= ev;
		query_temperature <= qt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic do_load(input logic obs, input logic [8:0] idx, input logic [19:0] et,
			input logic [15:0] eu, input logic [15:0] ev);
		loaded_temp[obs][idx] = et;
		send_item(FUNC_LOAD, obs, idx, et, eu, ev, 20'($urandom));
	endtask

	task automatic do_query(input logic obs, input logic [19:0] qt);
		send_item(FUNC_QUERY, obs, 9'($urandom), 20'($urandom), 16'($urandom),
			16'($urandom), qt);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ENTRIES_ADDR;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_entries(input logic [9:0] cnt, output int unsigned eff);
		wait_quiet();
		apb_access(1'b1, {22'($urandom), cnt});
		apb_access(1'b0, 32'($urandom));
		eff = cnt < 2 ? 2 : (cnt > TABLE_DEPTH ? TABLE_DEPTH : cnt);
	endtask

	task automatic load_table(input logic obs, input int unsigned cnt);
		longint unsigned acc;
		longint unsigned step_max;
		int unsigned     shape;
		int unsigned     i;
		bit              top_end;
		logic [19:0]     et;
		shape   = $urandom_range(9);
		acc     = ($urandom_range(7) == 0) ? 0 : $urandom_range(4000);
		step_max = (shape[0]) ? (TEMP_MAX - acc) / cnt : 8;
		top_end = ($urandom_range(7) == 0);
		for (i = 0; i < cnt; i++) begin
			if (shape < 2)
				et = 20'($urandom);
			else if (top_end && i == cnt - 1)
				et = TEMP_MAX;
			else
				et = (acc > TEMP_MAX) ? TEMP_MAX : 20'(acc);
			do_load(obs, 9'(i), et, 16'($urandom), 16'($urandom));
			if ($urandom_range(7) != 0)
				acc += $urandom_range(0, 32'(step_max));
		end
	endtask

	function automatic logic [19:0] pick_query(logic obs, int unsigned eff);
		logic [19:0] lo;
		logic [19:0] hi;
		int unsigned r;
		lo = loaded_temp[obs][0];
		hi = loaded_temp[obs][eff-1];
		r  = $urandom_range(99);
		if (r < 60)
			return 20'($urandom_range(lo, hi));
		if (r < 75)
			return loaded_temp[obs][$urandom_range(eff - 1)];
		if (r < 85)
			return 20'($urandom_range(0, lo));
		if (r < 95)
			return 20'($urandom_range(hi, TEMP_MAX));
		return 20'($urandom);
	endfunction

	initial begin
		int unsigned eff;
		int unsigned i;
		int unsigned nq;
		int unsigned sel;
		logic [9:0]  cnt;
		logic        obs;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		func = FUNC_LOAD;
		observer = 1'b0;
		entry_index = '0;
		entry_temperature = '0;
		entry_u = '0;
		entry_v = '0;
		query_temperature = '0;
		stall_cycles = 0;
		items_sent = 0;
		no_gaps = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill both tables, ascending
		for (i = 0; i < 2 * TABLE_DEPTH; i++)
			do_load(1'(i / TABLE_DEPTH), 9'(i % TABLE_DEPTH),
				20'((i % TABLE_DEPTH) * 2040 + $urandom_range(2039)),
				16'($urandom), 16'($urandom));

		do_query(1'b0, 20'd0);
		do_query(1'b0, TEMP_MAX);
		do_query(1'b1, loaded_temp[1][0]);
		do_query(1'b1, loaded_temp[1][5]);
		do_query(1'b1, loaded_temp[1][TABLE_DEPTH-1]);

		set_entries(10'd0, eff);
		do_load(1'b0, 9'd0, 20'd0, 16'd0, 16'hFFFF);
		do_load(1'b0, 9'd1, TEMP_MAX, 16'hFFFF, 16'd0);
		do_query(1'b0, 20'd1);
		do_query(1'b0, 20'h80000);
		do_query(1'b0, 20'hFFFFE);

		set_entries(10'd4, eff);
		do_load(1'b1, 9'd0, 20'd100, 16'($urandom), 16'($urandom));
		do_load(1'b1, 9'd1, 20'd300, 16'($urandom), 16'($urandom));
		do_load(1'b1, 9'd2, 20'd300, 16'($urandom), 16'($urandom));
		do_load(1'b1, 9'd3, 20'd500, 16'($urandom), 16'($urandom));
		do_query(1'b1, 20'd300);
		do_query(1'b1, 20'd200);
		do_query(1'b1, 20'd400);
		// out of order: first bracketing pair wins
		do_load(1'b0, 9'd0, 20'd100, 16'($urandom), 16'($urandom));
		do_load(1'b0, 9'd1, 20'd600, 16'($urandom), 16'($urandom));
		do_load(1'b0, 9'd2, 20'd50, 16'($urandom), 16'($urandom));
		do_load(1'b0, 9'd3, 20'd800, 16'($urandom), 16'($urandom));
		do_query(1'b0, 20'd700);
		do_query(1'b0, 20'd400);

		set_entries(10'h3FF, eff);
		do_query(1'b0, 20'($urandom_range(801, loaded_temp[0][TABLE_DEPTH-1] - 1)));

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 8)
				cnt = 10'($urandom_range(1));
			else if (sel < 70)
				cnt = 10'($urandom_range(2, 16));
			else if (sel < 88)
				cnt = 10'($urandom_range(17, 64));
			else if (sel < 94)
				cnt = 10'd512;
			else
				cnt = 10'($urandom_range(513, 1023));
			set_entries(cnt, eff);
			no_gaps = ($urandom_range(3) == 0);
			obs = 1'($urandom);
			if (eff <= 64)
				load_table(obs, eff);
			nq = (eff >= TABLE_DEPTH) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			repeat (nq) begin
				if ($urandom_range(7) == 0)
					do_load(1'($urandom), 9'($urandom), 20'($urandom), 16'($urandom),
						16'($urandom));
				if ($urandom_range(99) < 85)
					do_query(obs, pick_query(obs, eff));
				else
					do_query(~obs, pick_query(~obs, eff));
			end
		end

		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (64) @(negedge clk);
		if (mismatches == 0)
			$display("[planckian_locus_interpolator] OK");
		else
			$display("[planckian_locus_interpolator] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/plli_pkg.sv
rtl/plli_table.sv
rtl/plli_div.sv
rtl/planckian_locus_interpolator.sv
tb/plli_locus_checker.sv
tb/tb_planckian_locus_interpolator.sv
